### rtl/core/pov_pkg.sv
// shared types and constants for the pairwise overlap repulsion block
// no dependencies
package pov_pkg;

  // offsets at or beyond 2^MAG_W on any axis are treated as far apart
  localparam int MAG_W   = 25;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RAD_W   = 24;
  localparam int GAIN_W  = 32;
  localparam int DELTA_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

  typedef enum logic [1:0] {
    CONTACT_NONE  = 2'd0,
    CONTACT_HIT   = 2'd1,
    CONTACT_COINC = 2'd2
  } contact_e;

  // per-item sideband that rides along the sqrt and divide pipelines
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [MAG_W-1:0]      s;
    contact_e              code;
  } pov_side_t;

endpackage

### rtl/core/pov_in_if.sv
// input item channel: valid/ready handshake with the two sphere descriptions
// depends on pov_pkg
interface pov_in_if #(
  parameter int POS_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [POS_WIDTH-1:0]    pos_a_x;
  logic signed [POS_WIDTH-1:0]    pos_a_y;
  logic signed [POS_WIDTH-1:0]    pos_a_z;
  logic signed [POS_WIDTH-1:0]    pos_b_x;
  logic signed [POS_WIDTH-1:0]    pos_b_y;
  logic signed [POS_WIDTH-1:0]    pos_b_z;
  logic [pov_pkg::RAD_W-1:0]      radius_a;
  logic [pov_pkg::RAD_W-1:0]      radius_b;

  modport source (
    output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           radius_a, radius_b,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           radius_a, radius_b,
    output ready
  );
endinterface

### rtl/core/pov_out_if.sv
// result item channel: valid/ready handshake with velocity change and contact
// depends on pov_pkg
interface pov_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pov_pkg::DELTA_W-1:0] delta_vx;
  logic signed [pov_pkg::DELTA_W-1:0] delta_vy;
  logic signed [pov_pkg::DELTA_W-1:0] delta_vz;
  logic [1:0]                         contact;

  modport source (
    output valid, delta_vx, delta_vy, delta_vz, contact,
    input  ready
  );
  modport sink (
    input  valid, delta_vx, delta_vy, delta_vz, contact,
    output ready
  );
endinterface

### rtl/core/pov_front.sv
// front end: offsets, squares, squared distance sum and contact decision
// three register stages; depends on pov_pkg
module pov_front #(
  parameter int POS_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [2:0][POS_WIDTH-1:0]          pos_a_i,
  input  logic [2:0][POS_WIDTH-1:0]          pos_b_i,
  input  logic [pov_pkg::RAD_W-1:0]          radius_a_i,
  input  logic [pov_pkg::RAD_W-1:0]          radius_b_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output pov_pkg::pov_side_t                 side_o,
  output logic [pov_pkg::SQ_W-1:0]           sumsq_o
);

  localparam int N  = 3;
  localparam int DW = POS_WIDTH + 1;
  localparam int MW = pov_pkg::MAG_W;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // stall chain: a stage loads when empty or when the next one moves
  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  // stage 0: signed offsets and their magnitudes, and the radius sum
  logic [2:0][MW-1:0] mag_d;
  logic [2:0]         neg_d;
  logic               far_d;
  logic               zero_d;
  logic [DW-1:0]      dif   [3];
  logic [DW-1:0]      dmag  [3];
  logic [63:0]        dwide [3];

  always_comb begin
    far_d  = 1'b0;
    zero_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      dif[a]   = {pos_a_i[a][POS_WIDTH-1], pos_a_i[a]} - {pos_b_i[a][POS_WIDTH-1], pos_b_i[a]};
      neg_d[a] = dif[a][DW-1];
      dmag[a]  = neg_d[a] ? (~dif[a] + 1'b1) : dif[a];
      dwide[a] = 64'(dmag[a]);
      mag_d[a] = dwide[a][MW-1:0];
      if (|dwide[a][63:MW]) begin
        far_d = 1'b1;
      end
      if (dif[a] != '0) begin
        zero_d = 1'b0;
      end
    end
  end

  logic [2:0][MW-1:0] mag0_q;
  logic [2:0]         neg0_q;
  logic [MW-1:0]      s0_q;
  logic               far0_q, zero0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag0_q  <= mag_d;
      neg0_q  <= neg_d;
      s0_q    <= MW'(radius_a_i) + MW'(radius_b_i);
      far0_q  <= far_d;
      zero0_q <= zero_d;
    end
  end

  // stage 1: squares of each axis and of the radius sum
  logic [2:0][pov_pkg::SQ_W-1:0] sq1_q;
  logic [pov_pkg::SQ_W-1:0]      ss1_q;
  logic [2:0][MW-1:0]            mag1_q;
  logic [2:0]                    neg1_q;
  logic [MW-1:0]                 s1_q;
  logic                          far1_q, zero1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        sq1_q[a] <= pov_pkg::SQ_W'(mag0_q[a]) * pov_pkg::SQ_W'(mag0_q[a]);
      end
      ss1_q   <= pov_pkg::SQ_W'(s0_q) * pov_pkg::SQ_W'(s0_q);
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;
      s1_q    <= s0_q;
      far1_q  <= far0_q;
      zero1_q <= zero0_q;
    end
  end

  // stage 2: distance sum and contact classification
  logic [pov_pkg::SUM_W-1:0] sum_d;
  pov_pkg::contact_e         code_d;

  always_comb begin
    sum_d = pov_pkg::SUM_W'(sq1_q[0]) + pov_pkg::SUM_W'(sq1_q[1])
          + pov_pkg::SUM_W'(sq1_q[2]);
    if (far1_q || (pov_pkg::SUM_W'(ss1_q) <= sum_d)) begin
      code_d = pov_pkg::CONTACT_NONE;
    end else if (zero1_q) begin
      code_d = pov_pkg::CONTACT_COINC;
    end else begin
      code_d = pov_pkg::CONTACT_HIT;
    end
  end

  pov_pkg::pov_side_t       side2_q;
  logic [pov_pkg::SQ_W-1:0] sum2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      side2_q.mag  <= mag1_q;
      side2_q.neg  <= neg1_q;
      side2_q.s    <= s1_q;
      side2_q.code <= code_d;
      // on contact the sum is below s*s, so it fits the square width
      sum2_q       <= sum_d[pov_pkg::SQ_W-1:0];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign side_o  = side2_q;
  assign sumsq_o = sum2_q;

endmodule

### rtl/core/pov_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on pov_pkg
module pov_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  pov_pkg::pov_side_t       side_i,
  input  logic [pov_pkg::SQ_W-1:0] sumsq_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output pov_pkg::pov_side_t       side_o,
  output logic [pov_pkg::MAG_W-1:0] dist_o
);

  localparam int N = pov_pkg::MAG_W;
  localparam int W = pov_pkg::SQ_W;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // stall chain
  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  logic [W-1:0]       rem_q  [N];
  logic [W-1:0]       res_q  [N];
  pov_pkg::pov_side_t side_q [N];

  // one digit pair per stage, highest first
  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0]       rem_in, res_in, trial;
    pov_pkg::pov_side_t side_in;

    if (k == 0) begin : g_first
      assign rem_in  = sumsq_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
        side_q[k] <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign dist_o  = res_q[N-1][pov_pkg::MAG_W-1:0];

endmodule

### rtl/core/pov_div.sv
// force from overlap and gain, and restoring division of each offset by the
// distance, one quotient bit per stage; depends on pov_pkg
module pov_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  pov_pkg::pov_side_t                  side_i,
  input  logic [pov_pkg::MAG_W-1:0]           dist_i,
  input  logic [pov_pkg::GAIN_W-1:0]          gain_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output pov_pkg::pov_side_t                  side_o,
  output logic [pov_pkg::MAG_W+pov_pkg::GAIN_W-FRAC_BITS-1:0] force_o,
  output logic [2:0][FRAC_BITS:0]             unit_o
);

  localparam int N  = FRAC_BITS + 1;
  localparam int MW = pov_pkg::MAG_W;
  localparam int PW = pov_pkg::MAG_W + pov_pkg::GAIN_W;
  localparam int FW = PW - FRAC_BITS;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // stall chain
  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  logic [2:0][MW-1:0]   r_q     [N];
  logic [2:0][N-1:0]    q_q     [N];
  logic [MW-1:0]        dist_q  [N];
  logic [FW-1:0]        force_q [N];
  pov_pkg::pov_side_t   side_q  [N];

  // force = overlap * gain, taken once as the item enters
  logic [MW-1:0] ov;
  logic [PW-1:0] prod;
  assign ov   = side_i.s - dist_i;
  assign prod = PW'(ov) * PW'(gain_i);

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [2:0][MW:0]   r_cur;
    logic [2:0][N-1:0]  q_in;
    logic [2:0]         ge;
    logic [MW-1:0]      dist_in;
    logic [FW-1:0]      force_in;
    pov_pkg::pov_side_t side_in;

    if (k == 0) begin : g_first
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign r_cur[a] = {1'b0, side_i.mag[a]};
      end
      assign q_in     = '0;
      assign dist_in  = dist_i;
      assign force_in = prod[PW-1:FRAC_BITS];
      assign side_in  = side_i;
    end else begin : g_next
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign r_cur[a] = {r_q[k-1][a], 1'b0};
      end
      assign q_in     = q_q[k-1];
      assign dist_in  = dist_q[k-1];
      assign force_in = force_q[k-1];
      assign side_in  = side_q[k-1];
    end

    // trial subtract on all three axes
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        ge[a] = r_cur[a] >= {1'b0, dist_in};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        for (int a = 0; a < 3; a++) begin
          r_q[k][a] <= ge[a] ? MW'(r_cur[a] - {1'b0, dist_in}) : MW'(r_cur[a]);
          q_q[k][a] <= {q_in[a][N-2:0], ge[a]};
        end
        dist_q[k]  <= dist_in;
        force_q[k] <= force_in;
        side_q[k]  <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign force_o = force_q[N-1];
  assign unit_o  = q_q[N-1];

endmodule

### rtl/core/pov_back.sv
// back end: force times unit offset, sign, saturation and output register
// two register stages; depends on pov_pkg
module pov_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  pov_pkg::pov_side_t                  side_i,
  input  logic [pov_pkg::MAG_W+pov_pkg::GAIN_W-FRAC_BITS-1:0] force_i,
  input  logic [2:0][FRAC_BITS:0]             unit_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [2:0][pov_pkg::DELTA_W-1:0]    delta_o,
  output pov_pkg::contact_e                   contact_o
);

  localparam int N  = 2;
  localparam int FW = pov_pkg::MAG_W + pov_pkg::GAIN_W - FRAC_BITS;
  localparam int PW = FW + FRAC_BITS + 1;
  localparam int VW = PW - FRAC_BITS;
  localparam int OW = pov_pkg::DELTA_W;

  logic [N-1:0] v_q;
  logic [N-1:0] en;

  // stall chain
  always_comb begin
    en[N-1] = !v_q[N-1] || ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
        end
      end
    end
  end

  // stage 0: products per axis
  logic [2:0][PW-1:0] p_q;
  logic [2:0]         neg_q;
  pov_pkg::contact_e  code_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        p_q[a] <= PW'(force_i) * PW'(unit_i[a]);
      end
      neg_q  <= side_i.neg;
      code_q <= side_i.code;
    end
  end

  // stage 1: scale back, apply sign, saturate; zero unless force applies
  logic [2:0][OW-1:0] delta_d;
  logic [VW-1:0]      mag [3];
  logic               big [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = p_q[a][PW-1:FRAC_BITS];
      big[a] = |mag[a][VW-1:OW];
      if (code_q != pov_pkg::CONTACT_HIT) begin
        delta_d[a] = '0;
      end else if (neg_q[a]) begin
        if (big[a] || (mag[a][OW-1] && (|mag[a][OW-2:0]))) begin
          delta_d[a] = {1'b1, {(OW-1){1'b0}}};
        end else begin
          delta_d[a] = ~mag[a][OW-1:0] + 1'b1;
        end
      end else begin
        if (big[a] || mag[a][OW-1]) begin
          delta_d[a] = {1'b0, {(OW-1){1'b1}}};
        end else begin
          delta_d[a] = mag[a][OW-1:0];
        end
      end
    end
  end

  logic [2:0][OW-1:0] delta_q;
  pov_pkg::contact_e  contact_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      delta_q   <= delta_d;
      contact_q <= code_q;
    end
  end

  assign ready_o   = en[0];
  assign valid_o   = v_q[N-1];
  assign delta_o   = delta_q;
  assign contact_o = contact_q;

endmodule

### rtl/core/pairwise_overlap_repulsion.sv
// top level of the pairwise overlap repulsion block
// depends on pov_pkg, pov_in_if, pov_out_if, pov_front, pov_sqrt, pov_div, pov_back
//
// Usage: in_i carries one sphere pair per item (two centers and two radii,
// signed/unsigned fixed point with FRAC_BITS fraction bits); out_o returns the
// velocity change for the first sphere and a contact code (none, force
// applied, coincident centers). The second sphere takes the negated change.
// The gain register is written through cfg_we_i/cfg_wdata_i, which the user must
// do only while no item is in flight (the block has no check for this); it resets to 1.0.
// Throughput: one item per cycle while the receiver does not stall; every stage is fully pipelined.
// Stages from accept to result: 3 front-end stages, 25 square root stages,
// FRAC_BITS + 1 divide stages and 2 output stages.
// The square root and the per-axis divide pipelines are the deepest parts.
// Reset empties every stage and restores the gain; no clearing time needed.
// When the receiver stalls, results stay in the output register and bubbles
// inside the pipeline still close up, so in_i stays ready until every stage
// holds an item.
module pairwise_overlap_repulsion #(
  parameter int FRAC_BITS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pov_pkg::GAIN_W-1:0]    cfg_wdata_i,
  pov_in_if.sink                        in_i,
  pov_out_if.source                     out_o
);

  localparam int FW = pov_pkg::MAG_W + pov_pkg::GAIN_W - FRAC_BITS;

  // gain register
  logic [pov_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= pov_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // input fields gathered per axis
  logic [2:0][POS_WIDTH-1:0] pos_a, pos_b;
  assign pos_a = {in_i.pos_a_z, in_i.pos_a_y, in_i.pos_a_x};
  assign pos_b = {in_i.pos_b_z, in_i.pos_b_y, in_i.pos_b_x};

  logic                       fr_valid, fr_ready;
  pov_pkg::pov_side_t         fr_side;
  logic [pov_pkg::SQ_W-1:0]   fr_sumsq;

  pov_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .pos_a_i    (pos_a),
    .pos_b_i    (pos_b),
    .radius_a_i (in_i.radius_a),
    .radius_b_i (in_i.radius_b),
    .valid_o    (fr_valid),
    .ready_i    (fr_ready),
    .side_o     (fr_side),
    .sumsq_o    (fr_sumsq)
  );

  logic                       sq_valid, sq_ready;
  pov_pkg::pov_side_t         sq_side;
  logic [pov_pkg::MAG_W-1:0]  sq_dist;

  pov_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .side_i  (fr_side),
    .sumsq_i (fr_sumsq),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .side_o  (sq_side),
    .dist_o  (sq_dist)
  );

  logic                       dv_valid, dv_ready;
  pov_pkg::pov_side_t         dv_side;
  logic [FW-1:0]              dv_force;
  logic [2:0][FRAC_BITS:0]    dv_unit;

  pov_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .side_i  (sq_side),
    .dist_i  (sq_dist),
    .gain_i  (gain_q),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .side_o  (dv_side),
    .force_o (dv_force),
    .unit_o  (dv_unit)
  );

  logic [2:0][pov_pkg::DELTA_W-1:0] delta;
  pov_pkg::contact_e                contact;

  pov_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dv_valid),
    .ready_o   (dv_ready),
    .side_i    (dv_side),
    .force_i   (dv_force),
    .unit_i    (dv_unit),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .delta_o   (delta),
    .contact_o (contact)
  );

  assign out_o.delta_vx = delta[0];
  assign out_o.delta_vy = delta[1];
  assign out_o.delta_vz = delta[2];
  assign out_o.contact  = contact;

  // no contact or coincident centers always give a zero change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.contact != pov_pkg::CONTACT_HIT)
    |-> (out_o.delta_vx == '0) && (out_o.delta_vy == '0) && (out_o.delta_vz == '0))
    else $error("nonzero change without contact");

  // zero gain means no change even on contact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (gain_q == '0)
    |-> (out_o.delta_vx == '0) && (out_o.delta_vy == '0) && (out_o.delta_vz == '0))
    else $error("nonzero change with zero gain");

  // the input side only backs up when the output is held by the receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without output back pressure");

endmodule
